[rtl/utf8v_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared widths, status codes and the byte classification record.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    // Width of the saturating byte counter.
    localparam int COUNT_WIDTH = 21;
    // Width of the length limit register.
    localparam int LEN_WIDTH   = 21;
    // Common width for comparing the count against the limit.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
    // Reset value of the length limit.
    localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(1048576);

    // Depth of the queue between the classifier and the checker.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NUL      = 2'd2,
        ST_BAD_UTF8 = 2'd3
    } t_status;

    // Allowed range of the next continuation byte.
    typedef enum logic [2:0] {
        RC_PLAIN = 3'd0,   // 80..BF
        RC_E0    = 3'd1,   // A0..BF
        RC_ED    = 3'd2,   // 80..9F
        RC_F0    = 3'd3,   // 90..BF
        RC_F4    = 3'd4    // 80..8F
    } t_range;

    // One classified input byte.
    typedef struct packed {
        logic       is_last;
        logic       is_nul;
        logic [1:0] lead_pend;    // continuations that follow if taken as lead
        t_range     lead_range;   // range class set up if taken as lead
        logic       lead_bad;     // byte is not a legal lead byte
        logic [4:0] cont_ok;      // byte fits each continuation range class
    } t_class;

endpackage

[rtl/utf8_text_field_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 text field validator
// Strict UTF-8, NUL and length check of a byte stream, one status per text.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock unless a final byte waits for an occupied
// result slot; the final byte's status is registered there as it leaves the queue.
// A four-entry queue between classifier and checker absorbs output stalls.
// Reset (synchronous, active low) empties the queue and result slot, clears
// the per-text state and loads the length limit with 1048576.
// ----------------------------------------------------------------------------
module utf8_text_field_validator
    import utf8v_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_is_last,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_we,
    input  logic [LEN_WIDTH-1:0] i_cfg_wdata
);

    t_class              front_class;
    t_class              q_data;
    logic                q_empty;
    logic                q_rd;
    logic [QCOUNT_W-1:0] q_count;

    // Byte classification.
    utf8v_front u_front (
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .o_class     (front_class)
    );

    // Decoupling queue.
    utf8v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_class),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // Decoder, counters and result slot.
    utf8v_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_q_rd      (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_status    (o_status)
    );

    // The queue never holds more than its depth.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCOUNT_W'(QDEPTH))
        else $error("byte queue overfilled");

    // The checker never takes a byte from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == '0) |-> !q_rd)
        else $error("byte taken from empty queue");

    // After reset both sides are idle.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

endmodule

[rtl/utf8v_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator front end
// Classifies each raw byte both as a lead byte and as a continuation byte.
// ----------------------------------------------------------------------------
module utf8v_front
    import utf8v_pkg::*;
(
    input  logic [7:0] i_text_byte,
    input  logic       i_is_last,
    output t_class     o_class
);

    logic [1:0] lead_pend;
    t_range     lead_range;
    logic       lead_bad;

    // Lead byte decode: sequence length and special second-byte range.
    always_comb begin
        lead_pend  = 2'd0;
        lead_range = RC_PLAIN;
        lead_bad   = 1'b0;
        if (i_text_byte <= 8'h7F) begin
            lead_pend = 2'd0;
        end else if (i_text_byte >= 8'hC2 && i_text_byte <= 8'hDF) begin
            lead_pend = 2'd1;
        end else if (i_text_byte == 8'hE0) begin
            lead_pend  = 2'd2;
            lead_range = RC_E0;
        end else if (i_text_byte == 8'hED) begin
            lead_pend  = 2'd2;
            lead_range = RC_ED;
        end else if (i_text_byte >= 8'hE1 && i_text_byte <= 8'hEF) begin
            lead_pend = 2'd2;
        end else if (i_text_byte == 8'hF0) begin
            lead_pend  = 2'd3;
            lead_range = RC_F0;
        end else if (i_text_byte == 8'hF4) begin
            lead_pend  = 2'd3;
            lead_range = RC_F4;
        end else if (i_text_byte >= 8'hF1 && i_text_byte <= 8'hF3) begin
            lead_pend = 2'd3;
        end else begin
            lead_bad = 1'b1;
        end
    end

    // Continuation checks against every range class at once.
    always_comb begin
        o_class.is_last    = i_is_last;
        o_class.is_nul     = (i_text_byte == 8'h00);
        o_class.lead_pend  = lead_pend;
        o_class.lead_range = lead_range;
        o_class.lead_bad   = lead_bad;
        o_class.cont_ok[0] = (i_text_byte >= 8'h80) && (i_text_byte <= 8'hBF);
        o_class.cont_ok[1] = (i_text_byte >= 8'hA0) && (i_text_byte <= 8'hBF);
        o_class.cont_ok[2] = (i_text_byte >= 8'h80) && (i_text_byte <= 8'h9F);
        o_class.cont_ok[3] = (i_text_byte >= 8'h90) && (i_text_byte <= 8'hBF);
        o_class.cont_ok[4] = (i_text_byte >= 8'h80) && (i_text_byte <= 8'h8F);
    end

endmodule

[rtl/utf8v_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator byte queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module utf8v_queue
    import utf8v_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  t_class              i_wdata,
    output logic                o_full,
    input  logic                i_rd,
    output t_class              o_rdata,
    output logic                o_empty,
    output logic [QCOUNT_W-1:0] o_count
);

    t_class              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCOUNT_W-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];

    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = do_wr ? QPTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_rd ? QPTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = QCOUNT_W'(r_count + 1'b1);
        end else if (do_rd && !do_wr) begin
            n_count = QCOUNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[rtl/utf8v_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validator back end
// Runs the sequence decoder, NUL flag and length counter, and holds the result.
// ----------------------------------------------------------------------------
module utf8v_back
    import utf8v_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LEN_WIDTH-1:0] i_cfg_wdata,
    input  logic                 i_q_empty,
    input  t_class               i_q_data,
    output logic                 o_q_rd,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [1:0]           o_status
);

    logic [LEN_WIDTH-1:0]   r_max_len;
    logic [1:0]             r_pend, n_pend;
    t_range                 r_range, n_range;
    logic                   r_bad, n_bad;
    logic                   r_nul, n_nul;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic                   cont_ok;
    logic                   bad_final;
    logic                   too_long;

    // Take a byte unless it is final and the result slot stays occupied.
    assign o_q_rd = !i_q_empty && (!i_q_data.is_last || !r_out_valid || i_pop);

    // Continuation check for the current range class.
    always_comb begin
        case (r_range)
            RC_E0:   cont_ok = i_q_data.cont_ok[1];
            RC_ED:   cont_ok = i_q_data.cont_ok[2];
            RC_F0:   cont_ok = i_q_data.cont_ok[3];
            RC_F4:   cont_ok = i_q_data.cont_ok[4];
            default: cont_ok = i_q_data.cont_ok[0];
        endcase
    end

    // Per-text state update for one byte.
    always_comb begin
        n_count = r_count;
        if ((CMP_WIDTH'(r_count) <= CMP_WIDTH'(r_max_len)) && (r_count != '1)) begin
            n_count = COUNT_WIDTH'(r_count + 1'b1);
        end
        n_nul = r_nul | i_q_data.is_nul;
        n_bad = r_bad;
        if (r_pend != 2'd0) begin
            n_range = RC_PLAIN;
            if (cont_ok) begin
                n_pend = 2'(r_pend - 1'b1);
            end else begin
                n_pend = 2'd0;
                n_bad  = 1'b1;
            end
        end else begin
            n_pend  = i_q_data.lead_pend;
            n_range = i_q_data.lead_range;
            n_bad   = r_bad | i_q_data.lead_bad;
        end
    end

    // Final byte verdict in priority order.
    always_comb begin
        bad_final = n_bad || (n_pend != 2'd0);
        too_long  = CMP_WIDTH'(n_count) > CMP_WIDTH'(r_max_len);
        if (too_long) begin
            n_status = ST_TOO_LONG;
        end else if (n_nul) begin
            n_status = ST_NUL;
        end else if (bad_final) begin
            n_status = ST_BAD_UTF8;
        end else begin
            n_status = ST_VALID;
        end
    end

    // Result slot occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_q_rd && i_q_data.is_last) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state; per-text state is cleared at reset and after each final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= LEN_RESET;
            r_pend      <= 2'd0;
            r_range     <= RC_PLAIN;
            r_bad       <= 1'b0;
            r_nul       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
            if (o_q_rd) begin
                if (i_q_data.is_last) begin
                    r_pend  <= 2'd0;
                    r_range <= RC_PLAIN;
                    r_bad   <= 1'b0;
                    r_nul   <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_pend  <= n_pend;
                    r_range <= n_range;
                    r_bad   <= n_bad;
                    r_nul   <= n_nul;
                    r_count <= n_count;
                end
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (o_q_rd && i_q_data.is_last) begin
            r_status <= n_status;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_status = r_status;

endmodule
